>>> design/bipd_pkg.sv
`timescale 1ns / 1ps

package bipd_pkg;

  // quantization of the pulse durations
  localparam int unsigned LowDiv      = 430;
  localparam int unsigned HighDiv     = 550;
  localparam int unsigned RoundAdd    = 100;
  localparam int unsigned HeaderUnits = 5;

  // raw duration thresholds equivalent to the quantized unit compares
  localparam logic [15:0] LOW_LONG_MIN  = 16'((HeaderUnits + 1) * LowDiv - RoundAdd);
  localparam logic [15:0] LOW_HDR_MIN   = 16'(HeaderUnits * LowDiv - RoundAdd);
  localparam logic [15:0] LOW_TWO_MIN   = 16'(2 * LowDiv - RoundAdd);
  localparam logic [15:0] LOW_THREE_MIN = 16'(3 * LowDiv - RoundAdd);
  localparam logic [15:0] HIGH_ONE_MIN   = 16'(HighDiv - RoundAdd);
  localparam logic [15:0] HIGH_TWO_MIN   = 16'(2 * HighDiv - RoundAdd);
  localparam logic [15:0] HIGH_THREE_MIN = 16'(3 * HighDiv - RoundAdd);

  // frame layout
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CODE_BITS = 16;
  localparam logic [CNT_W-1:0] PHASE_TOP    = CNT_W'(33);
  localparam logic [CNT_W-1:0] FRAME_PHASES = CNT_W'(32);

  // result status codes
  typedef enum logic [1:0] {
    ST_WAIT   = 2'd0,
    ST_REJECT = 2'd1,
    ST_DONE   = 2'd2
  } status_t;

  // classification of one pulse pair
  typedef struct packed {
    logic long_low;   // low above header length
    logic hdr_low;    // low of exactly header length
    logic low_two;    // low of two units
    logic high_zero;  // high of zero units
    logic high_two;   // high of two units
  } pulse_class_t;

endpackage

>>> design/bipd_front.sv
`timescale 1ns / 1ps

module bipd_front (
  input  logic [15:0]           low_duration,
  input  logic [15:0]           high_duration,
  output bipd_pkg::pulse_class_t pulse_class
);
  import bipd_pkg::*;

  // unit compares folded into raw range checks
  always_comb begin
    pulse_class.long_low  = (low_duration >= LOW_LONG_MIN);
    pulse_class.hdr_low   = (low_duration >= LOW_HDR_MIN) && (low_duration < LOW_LONG_MIN);
    pulse_class.low_two   = (low_duration >= LOW_TWO_MIN) && (low_duration < LOW_THREE_MIN);
    pulse_class.high_zero = (high_duration < HIGH_ONE_MIN);
    pulse_class.high_two  = (high_duration >= HIGH_TWO_MIN) && (high_duration < HIGH_THREE_MIN);
  end

endmodule

>>> design/bipd_queue.sv
`timescale 1ns / 1ps

module bipd_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  bipd_pkg::pulse_class_t push_data,
  output logic                   full,
  input  logic                   pop,
  output logic                   head_valid,
  output bipd_pkg::pulse_class_t head_data
);
  import bipd_pkg::*;

  logic         valid0, valid1;
  pulse_class_t ent0, ent1;

  assign full       = valid1;
  assign head_valid = valid0;
  assign head_data  = ent0;

  // two-entry queue, head always in entry 0
  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
      valid1 <= 1'b0;
    end else begin
      priority if (pop && push) begin
        ent0 <= push_data;
      end else if (pop) begin
        ent0   <= ent1;
        valid0 <= valid1;
        valid1 <= 1'b0;
      end else if (push) begin
        if (!valid0) begin
          ent0   <= push_data;
          valid0 <= 1'b1;
        end else begin
          ent1   <= push_data;
          valid1 <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/bipd_back.sv
`timescale 1ns / 1ps

module bipd_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   head_valid,
  input  bipd_pkg::pulse_class_t head_data,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_status,
  output logic [15:0]            out_code
);
  import bipd_pkg::*;

  logic                   skip_flag, skip_flag_next;
  logic [CNT_W-1:0]       phase_count, phase_count_next;
  logic [WORD_W-1:0]      phase_word, phase_word_next;
  status_t                res_status;
  logic [CODE_BITS-1:0]   res_code;

  logic [CNT_W-1:0]       c1, c2, c_end;
  logic [WORD_W-1:0]      mask1, mask2, word_new;
  logic [CODE_BITS-1:0]   code_dec;

  // take a classified pulse when the result register is free
  assign pop = head_valid && (!out_valid || out_ready);

  // phase positions for one or two half-bit phases
  always_comb begin
    c1    = phase_count + CNT_W'(1) + CNT_W'(head_data.low_two);
    c2    = c1 + CNT_W'(1);
    c_end = c2 + CNT_W'(head_data.high_two);
    mask1 = (c1 <= PHASE_TOP) ? (WORD_W'(1) << (PHASE_TOP - c1)) : '0;
    mask2 = (head_data.high_two && (c2 <= PHASE_TOP)) ?
            (WORD_W'(1) << (PHASE_TOP - c2)) : '0;
    word_new = phase_word | mask1 | mask2;
  end

  // pair decode, lowest pair lands in the top code bit
  always_comb begin
    for (int i = 0; i < CODE_BITS; i++) begin
      code_dec[CODE_BITS-1-i] = word_new[2*i+1] & ~word_new[2*i];
    end
  end

  // frame state update
  always_comb begin
    skip_flag_next   = skip_flag;
    phase_count_next = phase_count;
    phase_word_next  = phase_word;
    res_status       = ST_WAIT;
    res_code         = '0;
    priority if (head_data.long_low) begin
      skip_flag_next   = 1'b0;
      phase_count_next = '0;
    end else if (skip_flag) begin
      res_status = ST_REJECT;
    end else if (phase_count > FRAME_PHASES) begin
      res_status = ST_REJECT;
    end else if (phase_count == '0) begin
      if (!head_data.hdr_low) begin
        skip_flag_next = 1'b1;
        res_status     = ST_REJECT;
      end else begin
        phase_count_next = CNT_W'(1);
        phase_word_next  = '0;
      end
    end else if (head_data.high_zero) begin
      skip_flag_next = 1'b1;
      res_status     = ST_REJECT;
    end else begin
      phase_count_next = c_end;
      if (c_end > FRAME_PHASES) begin
        phase_word_next = '0;
        res_status      = ST_DONE;
        res_code        = code_dec;
      end else begin
        phase_word_next = word_new;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_flag   <= 1'b0;
      phase_count <= '0;
      phase_word  <= '0;
    end else if (pop) begin
      skip_flag   <= skip_flag_next;
      phase_count <= phase_count_next;
      phase_word  <= phase_word_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_status <= res_status;
      out_code   <= res_code;
    end
  end

  // a finished frame never coexists with the skip flag
  assert property (@(posedge clk) disable iff (rst)
    !(skip_flag && (phase_count > FRAME_PHASES)))
    else $error("skip flag set on a completed frame");

  // a long low always restarts the frame
  assert property (@(posedge clk) disable iff (rst)
    pop && head_data.long_low |=> (phase_count == '0) && !skip_flag)
    else $error("long low did not restart the frame");

  // completion leaves an emptied word and a count past the frame
  assert property (@(posedge clk) disable iff (rst)
    pop && (res_status == ST_DONE) |=> (phase_word == '0) && (phase_count > FRAME_PHASES))
    else $error("completion state wrong");

  // code is zero unless the frame completed
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status != ST_DONE) |-> (out_code == '0))
    else $error("code set without completion");

endmodule

>>> design/biphase_ir_pulse_decoder.sv
`timescale 1ns / 1ps
// channel   direction  fields
// s_axis    in         s_tdata: low_duration[15:0], high_duration[31:16]
// m_axis    out        m_tdata: status[1:0], code[17:2], zero[23:18]
//
// one pulse pair per cycle sustained while m_tready stays high; each pair
// lands in the queue at accept, then moves on to the result register
// rst clears frame state, the two-entry queue and the result valid
// s_tready drops only when the queue holds two pairs; m_tready stalls the
// result register, the queue absorbs pairs meanwhile

module biphase_ir_pulse_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // low_duration[15:0], high_duration[31:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // status[1:0], code[17:2], zero[23:18]
);
  import bipd_pkg::*;

  pulse_class_t cls, head_data;
  logic         full, head_valid, pop;
  logic [1:0]   status;
  logic [15:0]  code;

  bipd_front u_front (
    .low_duration  (s_tdata[15:0]),
    .high_duration (s_tdata[31:16]),
    .pulse_class   (cls)
  );

  assign s_tready = !full;

  bipd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (s_tvalid && s_tready),
    .push_data  (cls),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  bipd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (status),
    .out_code   (code)
  );

  // pack result transaction
  assign m_tdata = {6'd0, code, status};

endmodule
